// ----- sv/first_fit_heap_allocator_assert.svh -----
`ifndef FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FFHA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffha assertion failed");

// next-cycle implication, disabled in reset
`define FFHA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffha assertion failed");

`endif

// ----- sv/ffha_pkg.sv -----
package ffha_pkg;

  localparam int MAX_BLOCKS   = 256;
  localparam int HEADER_BYTES = 8;
  localparam int ALIGN_BYTES  = 4;
  localparam int PAGE_MASK    = 32'hFFF;

  localparam int ADDR_W    = 24;
  localparam int SIZE_W    = 25;
  localparam int IDX_W     = $clog2(MAX_BLOCKS);
  localparam int CNT_W     = $clog2(MAX_BLOCKS + 1);
  localparam int CFG_IDX_W = 8;
  localparam int STATUS_W  = 3;

  localparam logic [SIZE_W-1:0] ADDR_TOP = 25'h100_0000;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NOOP    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_OOM     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_END  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 8'd1;

  // search token handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              act;
    logic [SIZE_W-1:0] key;         // rounded size, or release address minus header
    logic              key_ok;
    logic [CNT_W-1:0]  count;
    logic              append_ok;
    logic [ADDR_W-1:0] append_base;
    logic              resolved;
    logic              appended;
    logic              hit_busy;
    logic [ADDR_W-1:0] hit_base;
    logic [ADDR_W-1:0] hit_bytes;
  } ffha_tok_t;

endpackage

// ----- sv/ffha_if.sv -----
interface ffha_in_if;
  import ffha_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [ADDR_W-1:0] request_bytes;
  logic [ADDR_W-1:0] release_address;
  modport source(output valid, action, request_bytes, release_address, input ready);
  modport sink(input valid, action, request_bytes, release_address, output ready);
endinterface

interface ffha_out_if;
  import ffha_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   granted_address;
  logic [STATUS_W-1:0] status;
  logic [SIZE_W-1:0]   bytes_in_use;
  modport source(output valid, granted_address, status, bytes_in_use, input ready);
  modport sink(input valid, granted_address, status, bytes_in_use, output ready);
endinterface

interface ffha_cfg_if;
  import ffha_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- sv/ffha_cell.sv -----
module ffha_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ffha_pkg::IDX_W-1:0] idx,
  input  ffha_pkg::ffha_tok_t       tok_in,
  output ffha_pkg::ffha_tok_t       tok_out
);
  import ffha_pkg::*;

  logic [ADDR_W-1:0] base, base_next;
  logic [ADDR_W-1:0] bytes, bytes_next;
  logic              busy, busy_next;
  ffha_tok_t         tok_next;
  logic              in_range;
  logic              at_end;

  assign in_range = {1'b0, idx} < tok_in.count;
  assign at_end   = {1'b0, idx} == tok_in.count;

  always_comb begin
    tok_next   = tok_in;
    base_next  = base;
    bytes_next = bytes;
    busy_next  = busy;
    if (tok_in.valid && !tok_in.resolved) begin
      if (tok_in.act == ACT_ALLOC) begin
        if (in_range && !busy && ({1'b0, bytes} >= tok_in.key)) begin
          busy_next          = 1'b1;
          tok_next.resolved  = 1'b1;
          tok_next.hit_base  = base;
          tok_next.hit_bytes = bytes;
        end else if (at_end && tok_in.append_ok) begin
          base_next          = tok_in.append_base;
          bytes_next         = tok_in.key[ADDR_W-1:0];
          busy_next          = 1'b1;
          tok_next.resolved  = 1'b1;
          tok_next.appended  = 1'b1;
          tok_next.hit_base  = tok_in.append_base;
          tok_next.hit_bytes = tok_in.key[ADDR_W-1:0];
        end
      end else begin
        if (in_range && tok_in.key_ok && (base == tok_in.key[ADDR_W-1:0])) begin
          busy_next          = 1'b0;
          tok_next.resolved  = 1'b1;
          tok_next.hit_busy  = busy;
          tok_next.hit_bytes = bytes;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    base  <= base_next;
    bytes <= bytes_next;
    if (rst) begin
      busy    <= 1'b0;
      tok_out <= '0;
    end else begin
      busy    <= busy_next;
      tok_out <= tok_next;
    end
  end

endmodule

// ----- sv/ffha_ctrl.sv -----
module ffha_ctrl (
  input  logic                clk,
  input  logic                rst,
  ffha_in_if.sink             alloc_in,
  ffha_out_if.source          alloc_out,
  ffha_cfg_if.sink            cfg,
  output ffha_pkg::ffha_tok_t tok_launch,
  input  ffha_pkg::ffha_tok_t tok_done
);
  import ffha_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]        state;
  logic              act;
  logic [ADDR_W-1:0] req;
  logic [ADDR_W-1:0] rel;
  logic [SIZE_W-1:0] size;
  logic              noop;
  logic              oom;
  logic [SIZE_W-1:0] limit;
  logic [SIZE_W-1:0] bump;
  logic [SIZE_W-1:0] used;
  logic [CNT_W-1:0]  count;
  ffha_tok_t         done;

  logic              oom_now;
  logic              out_free;
  logic [STATUS_W-1:0] fin_status;
  logic [ADDR_W-1:0]   fin_addr;
  logic [SIZE_W-1:0]   fin_used;
  logic [SIZE_W-1:0]   restart_bump;
  logic [SIZE_W-1:0]   blk_bytes;

  assign alloc_in.ready = (state == S_IDLE);
  assign cfg.ready      = (state == S_IDLE);
  assign out_free       = !alloc_out.valid || alloc_out.ready;

  assign oom_now = ({1'b0, bump} + (SIZE_W+1)'(HEADER_BYTES) + {1'b0, size}) >= {1'b0, limit};
  assign restart_bump = ({1'b0, cfg.data[ADDR_W-1:0]} + SIZE_W'(PAGE_MASK))
                        & ~SIZE_W'(PAGE_MASK);
  assign blk_bytes = {1'b0, done.hit_bytes} + SIZE_W'(HEADER_BYTES);

  always_comb begin
    tok_launch             = '0;
    tok_launch.valid       = (state == S_LAUNCH);
    tok_launch.act         = act;
    tok_launch.count       = count;
    tok_launch.append_base = bump[ADDR_W-1:0];
    if (act == ACT_ALLOC) begin
      tok_launch.key       = size;
      tok_launch.key_ok    = 1'b1;
      tok_launch.append_ok = !oom_now && (count < CNT_W'(MAX_BLOCKS));
    end else begin
      tok_launch.key       = {1'b0, rel} - SIZE_W'(HEADER_BYTES);
      tok_launch.key_ok    = rel >= ADDR_W'(HEADER_BYTES);
      tok_launch.append_ok = 1'b0;
    end
  end

  always_comb begin
    fin_status = ST_NOOP;
    fin_addr   = '0;
    fin_used   = used;
    if (!noop) begin
      if (act == ACT_ALLOC) begin
        if (done.resolved) begin
          fin_status = ST_OK;
          fin_addr   = done.hit_base + ADDR_W'(HEADER_BYTES);
          fin_used   = used + blk_bytes;
        end else begin
          fin_status = oom ? ST_OOM : ST_FULL;
        end
      end else begin
        if (!done.resolved) begin
          fin_status = ST_UNKNOWN;
        end else if (done.hit_busy) begin
          fin_status = ST_OK;
          fin_used   = used - blk_bytes;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      limit           <= ADDR_TOP;
      bump            <= '0;
      used            <= '0;
      count           <= '0;
      alloc_out.valid <= 1'b0;
    end else begin
      if ((state == S_FIN) && out_free) begin
        alloc_out.valid <= 1'b1;
      end else if (alloc_out.valid && alloc_out.ready) begin
        alloc_out.valid <= 1'b0;
      end
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_IMAGE_END) begin
          bump  <= restart_bump;
          used  <= '0;
          count <= '0;
        end else if (cfg.index == REG_HEAP_LIMIT) begin
          limit <= (cfg.data > ADDR_TOP) ? ADDR_TOP : cfg.data;
        end
      end
      unique case (state)
        S_IDLE: begin
          if (alloc_in.valid) begin
            act   <= alloc_in.action;
            req   <= alloc_in.request_bytes;
            rel   <= alloc_in.release_address;
            state <= S_PREP;
          end
        end
        S_PREP: begin
          size <= ({1'b0, req} + SIZE_W'(ALIGN_BYTES - 1)) & ~SIZE_W'(ALIGN_BYTES - 1);
          if (act == ACT_ALLOC) begin
            noop <= (req == '0);
            state <= (req == '0) ? S_FIN : S_LAUNCH;
          end else begin
            noop <= (rel == '0);
            state <= (rel == '0) ? S_FIN : S_LAUNCH;
          end
        end
        S_LAUNCH: begin
          oom   <= oom_now;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (tok_done.valid) begin
            done  <= tok_done;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            alloc_out.status          <= fin_status;
            alloc_out.granted_address <= fin_addr;
            alloc_out.bytes_in_use    <= fin_used;
            used                      <= fin_used;
            if (!noop && (act == ACT_ALLOC) && done.appended) begin
              bump  <= bump + blk_bytes;
              count <= count + CNT_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/first_fit_heap_allocator.sv -----
// First-fit heap allocator. Each block-table entry (base, payload size, in-use mark)
// lives in one cell of a chain of MAX_BLOCKS cells; an allocate or free request runs
// down the chain as a token, one cell per clock, and the first matching cell claims,
// releases or (past the last used entry) creates the block. One transaction is in
// work at a time: an allocate or free runs through prepare, launch, the cell chain
// and the finish state before its result is offered; a zero-size allocate or a null
// free goes from prepare straight to finish. The next request is accepted as soon as
// the result sits in the output register, even if it has not been taken.
// Writing the image-end register restarts the heap; configuration is taken only while
// the controller is idle, one write per cycle, and must only be written while no
// request is in work.
module first_fit_heap_allocator (
  input logic        clk,
  input logic        rst,
  ffha_in_if.sink    alloc_in,
  ffha_out_if.source alloc_out,
  ffha_cfg_if.sink   cfg
);
  import ffha_pkg::*;

  ffha_tok_t chain [MAX_BLOCKS+1];

  ffha_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .alloc_in   (alloc_in),
    .alloc_out  (alloc_out),
    .cfg        (cfg),
    .tok_launch (chain[0]),
    .tok_done   (chain[MAX_BLOCKS])
  );

  for (genvar i = 0; i < MAX_BLOCKS; i++) begin : g_cell
    ffha_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (IDX_W'(i)),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

endmodule

// ----- sv/ffha_checker.sv -----
`include "first_fit_heap_allocator_assert.svh"

module ffha_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [ffha_pkg::ADDR_W-1:0]    out_addr,
  input logic [ffha_pkg::STATUS_W-1:0]  out_status,
  input logic [ffha_pkg::SIZE_W-1:0]    out_used
);
  import ffha_pkg::*;

  // one transaction in work at a time
  `FFHA_ASSERT_NEXT(a_one_in_work, clk, rst, in_valid && in_ready, !in_ready)
  `FFHA_ASSERT_NOW(a_status_range, clk, rst, out_valid, out_status <= ST_UNKNOWN)
  `FFHA_ASSERT_NOW(a_addr_zero_unless_ok, clk, rst, out_valid && (out_status != ST_OK), out_addr == '0)
  `FFHA_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_addr) && $stable(out_status) && $stable(out_used))

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (alloc_in.valid),
  .in_ready   (alloc_in.ready),
  .out_valid  (alloc_out.valid),
  .out_ready  (alloc_out.ready),
  .out_addr   (alloc_out.granted_address),
  .out_status (alloc_out.status),
  .out_used   (alloc_out.bytes_in_use)
);

// ----- bench/first_fit_heap_allocator_tb.sv -----
`timescale 1ns / 100ps

module first_fit_heap_allocator_tb;
  import ffha_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = 8'hFF;
  localparam int NUM_STATUS = 5;

  typedef struct packed {
    logic [ADDR_W-1:0]   granted_address;
    logic [STATUS_W-1:0] status;
    logic [SIZE_W-1:0]   bytes_in_use;
  } heap_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ffha_in_if  req_bus ();
  ffha_out_if rsp_bus ();
  ffha_cfg_if cfg_bus ();

  first_fit_heap_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .alloc_in  (req_bus),
    .alloc_out (rsp_bus),
    .cfg       (cfg_bus)
  );

  // shadow of the block table and heap registers
  logic [ADDR_W-1:0] blk_base  [MAX_BLOCKS];
  logic [ADDR_W-1:0] blk_bytes [MAX_BLOCKS];
  logic              blk_busy  [MAX_BLOCKS];
  int                blk_count;
  logic [SIZE_W-1:0] bump_ptr;
  logic [SIZE_W-1:0] used_bytes;
  logic [ADDR_W-1:0] image_end_reg;
  logic [SIZE_W-1:0] heap_limit_reg;

  heap_reply_t awaited_replies[$];
  int error_count;
  int sent_count;
  int checked_count;
  int cfg_count;
  int status_seen [NUM_STATUS];
  bit no_gaps;

  always #5 clk = ~clk;

  function automatic void restart_heap_shadow();
    for (int i = 0; i < MAX_BLOCKS; i++) blk_busy[i] = 1'b0;
    blk_count  = 0;
    used_bytes = '0;
    bump_ptr   = SIZE_W'((32'(image_end_reg) + PAGE_MASK) & ~PAGE_MASK);
  endfunction

  function automatic void shadow_register_write(logic [CFG_IDX_W-1:0] idx,
                                                logic [SIZE_W-1:0] data);
    if (idx == REG_IMAGE_END) begin
      image_end_reg = data[ADDR_W-1:0];
      restart_heap_shadow();
    end else if (idx == REG_HEAP_LIMIT) begin
      heap_limit_reg = data;
    end
  endfunction

  function automatic heap_reply_t predict_allocate(logic [ADDR_W-1:0] req);
    heap_reply_t r;
    logic [31:0] size;
    logic [31:0] limit;
    r.granted_address = '0;
    r.status = ST_OK;
    if (req == '0) begin
      r.status = ST_NOOP;
      r.bytes_in_use = used_bytes;
      return r;
    end
    size  = (32'(req) + ALIGN_BYTES - 1) & ~32'(ALIGN_BYTES - 1);
    limit = (heap_limit_reg < ADDR_TOP) ? 32'(heap_limit_reg) : 32'(ADDR_TOP);
    for (int i = 0; i < blk_count; i++) begin
      if (!blk_busy[i] && 32'(blk_bytes[i]) >= size) begin
        blk_busy[i] = 1'b1;
        used_bytes = SIZE_W'(used_bytes + blk_bytes[i] + HEADER_BYTES);
        r.granted_address = ADDR_W'(blk_base[i] + HEADER_BYTES);
        r.bytes_in_use = used_bytes;
        return r;
      end
    end
    if (32'(bump_ptr) + HEADER_BYTES + size >= limit) begin
      r.status = ST_OOM;
    end else if (blk_count >= MAX_BLOCKS) begin
      r.status = ST_FULL;
    end else begin
      blk_base[blk_count]  = bump_ptr[ADDR_W-1:0];
      blk_bytes[blk_count] = size[ADDR_W-1:0];
      blk_busy[blk_count]  = 1'b1;
      blk_count++;
      r.granted_address = ADDR_W'(bump_ptr + HEADER_BYTES);
      bump_ptr   = SIZE_W'(bump_ptr + HEADER_BYTES + size);
      used_bytes = SIZE_W'(used_bytes + HEADER_BYTES + size);
    end
    r.bytes_in_use = used_bytes;
    return r;
  endfunction

  function automatic heap_reply_t predict_release(logic [ADDR_W-1:0] addr);
    heap_reply_t r;
    r.granted_address = '0;
    r.status = ST_UNKNOWN;
    if (addr == '0) begin
      r.status = ST_NOOP;
    end else begin
      for (int i = 0; i < blk_count; i++) begin
        if (32'(blk_base[i]) + HEADER_BYTES == 32'(addr)) begin
          if (blk_busy[i]) begin
            blk_busy[i] = 1'b0;
            used_bytes = SIZE_W'(used_bytes - blk_bytes[i] - HEADER_BYTES);
            r.status = ST_OK;
          end else begin
            r.status = ST_NOOP;
          end
          r.bytes_in_use = used_bytes;
          return r;
        end
      end
    end
    r.bytes_in_use = used_bytes;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_known_address();
    if (blk_count == 0) return '0;
    return ADDR_W'(blk_base[$urandom_range(0, blk_count - 1)] + HEADER_BYTES);
  endfunction

  function automatic logic [ADDR_W-1:0] random_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return ADDR_W'($urandom_range(1, 64));
    if (r < 85) return ADDR_W'($urandom_range(1, 1024));
    if (r < 95) return ADDR_W'($urandom_range(1, 65535));
    return ADDR_W'($urandom);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  // response checker
  always @(posedge clk) begin
    heap_reply_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (rsp_bus.status < NUM_STATUS) status_seen[rsp_bus.status]++;
      if (awaited_replies.size() == 0) begin
        report_mismatch("unexpected response status", '0, 32'(rsp_bus.status));
      end else begin
        want = awaited_replies.pop_front();
        checked_count++;
        if (rsp_bus.granted_address !== want.granted_address)
          report_mismatch("granted_address", 32'(want.granted_address),
                          32'(rsp_bus.granted_address));
        if (rsp_bus.status !== want.status)
          report_mismatch("status", 32'(want.status), 32'(rsp_bus.status));
        if (rsp_bus.bytes_in_use !== want.bytes_in_use)
          report_mismatch("bytes_in_use", 32'(want.bytes_in_use), 32'(rsp_bus.bytes_in_use));
      end
    end
  end

  // response back-pressure
  initial begin
    rsp_bus.ready = 1'b1;
    forever begin
      @(negedge clk);
      rsp_bus.ready <= no_gaps || ($urandom_range(0, 99) >= 25);
    end
  end

  task automatic send_request(logic act, logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] rel);
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 99) < 25) begin
      req_bus.valid <= 1'b0;
      if ($urandom_range(0, 99) < 20) repeat ($urandom_range(1, 300)) @(negedge clk);
      else repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    req_bus.valid           <= 1'b1;
    req_bus.action          <= act;
    req_bus.request_bytes   <= req;
    req_bus.release_address <= rel;
    do @(posedge clk); while (!req_bus.ready);
    sent_count++;
    if (act == ACT_ALLOC) awaited_replies.push_back(predict_allocate(req));
    else awaited_replies.push_back(predict_release(rel));
  endtask

  task automatic allocate(logic [ADDR_W-1:0] req);
    send_request(ACT_ALLOC, req, ADDR_W'($urandom));
  endtask

  task automatic release_block(logic [ADDR_W-1:0] addr);
    send_request(ACT_FREE, ADDR_W'($urandom), addr);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_count++;
    shadow_register_write(idx, data);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_operations();
    allocate('0);                 // zero size
    release_block('0);            // null free
    allocate(24'd1);
    allocate(24'hFFFFFF);         // exhausted
    allocate(24'd5);
    release_block(24'd8);
    release_block(24'd8);         // double free
    allocate(24'd3);              // reuses the freed block
    release_block(24'hFFFFFF);    // unknown
    release_block(24'd12);        // inside a block, unknown
    allocate(24'h800000);
    release_block(24'd20);
    allocate(24'd8);
    allocate(24'd9);
  endtask

  task automatic test_register_settings();
    wait_idle();
    write_register(REG_IMAGE_END, 25'h1FFFFFF);   // heap starts at the top
    allocate(24'd4);
    release_block(24'd8);
    wait_idle();
    write_register(REG_IMAGE_END, 25'h001001);
    write_register(REG_HEAP_LIMIT, 25'h002018);
    allocate(24'd16);             // end lands exactly on the limit
    allocate(24'd12);
    wait_idle();
    write_register(REG_HEAP_LIMIT, '0);
    allocate(24'd1);
    release_block(24'h002008);
    allocate(24'd4);              // reuse ignores the limit
    wait_idle();
    write_register(REG_HEAP_LIMIT, 25'h1FFFFFF); // saturates
    allocate(24'hFFFFFF);
    allocate(24'hFF0000);
    wait_idle();
    write_register(REG_SPARE, '0);
    write_register(REG_LAST, '0);
    allocate(24'd4);
  endtask

  task automatic test_table_full();
    wait_idle();
    write_register(REG_IMAGE_END, 25'h123456);
    write_register(REG_HEAP_LIMIT, ADDR_TOP);
    no_gaps = 1'b1;
    repeat (MAX_BLOCKS) allocate(ADDR_W'($urandom_range(1, 32)));
    allocate(24'd64);
    no_gaps = 1'b0;
    wait_idle();
    write_register(REG_HEAP_LIMIT, SIZE_W'(bump_ptr + HEADER_BYTES + 40));
    allocate(24'd64);             // exhaustion wins over a full table
    allocate(24'd32);
    repeat (8) release_block(pick_known_address());
    repeat (16) allocate(ADDR_W'($urandom_range(1, 40)));
  endtask

  task automatic test_random_traffic(int items, int alloc_pct);
    int pick;
    logic [SIZE_W-1:0] lim;
    wait_idle();
    write_register(REG_IMAGE_END, {1'($urandom), ADDR_W'($urandom_range(0, 24'hEFFFFF))});
    if ($urandom_range(0, 99) < 30) lim = SIZE_W'(ADDR_TOP + $urandom_range(0, 24'hFFFFFF));
    else lim = SIZE_W'(bump_ptr + $urandom_range(4096, 65536));
    write_register(REG_HEAP_LIMIT, lim);
    repeat (items) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) allocate(random_size());
      else if (pick < 93) release_block(pick_known_address());
      else if (pick < 95) release_block(ADDR_W'($urandom));
      else if (pick < 97) release_block(ADDR_W'(pick_known_address() + 4));
      else if (pick < 98) allocate('0);
      else release_block('0);
    end
  endtask

  initial begin
    req_bus.valid           = 1'b0;
    req_bus.action          = ACT_ALLOC;
    req_bus.request_bytes   = '0;
    req_bus.release_address = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = REG_IMAGE_END;
    cfg_bus.data            = '0;
    no_gaps       = 1'b0;
    error_count   = 0;
    sent_count    = 0;
    checked_count = 0;
    cfg_count     = 0;
    for (int i = 0; i < NUM_STATUS; i++) status_seen[i] = 0;
    image_end_reg  = '0;
    heap_limit_reg = ADDR_TOP;
    restart_heap_shadow();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_operations();
    test_register_settings();
    test_table_full();
    test_random_traffic(235, 50);
    test_random_traffic(235, 70);
    test_random_traffic(235, 45);
    test_random_traffic(235, 60);
    test_random_traffic(235, 80);
    test_random_traffic(235, 55);

    wait_idle();
    repeat (300) @(posedge clk);
    $display("Sent %0d requests, checked %0d responses, %0d register writes",
             sent_count, checked_count, cfg_count);
    $display("Responses seen: ok %0d, no-op %0d, out of memory %0d, table full %0d, unknown %0d",
             status_seen[ST_OK], status_seen[ST_NOOP], status_seen[ST_OOM],
             status_seen[ST_FULL], status_seen[ST_UNKNOWN]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d responses outstanding", awaited_replies.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/ffha_pkg.sv
sv/ffha_if.sv
sv/ffha_cell.sv
sv/ffha_ctrl.sv
sv/first_fit_heap_allocator.sv
sv/ffha_checker.sv
bench/first_fit_heap_allocator_tb.sv
